FILE: hdl/adcsa_pkg.sv
`default_nettype none

package adcsa_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CHAN_IN_W    = 3;
    localparam int SCAN_W       = 2;
    localparam int CODE_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 5;
    localparam int SETUP_W      = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 6;
    localparam int NUM_CFG_CH   = 4;

    // sum of up to 31 samples, and its magnitude
    localparam int SUM_W        = SAMPLE_W + COUNT_W;
    localparam int MAG_W        = SUM_W - 1;
    localparam int DIV_CNT_W    = $clog2(MAG_W + 1);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_BASE = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_DISCARD   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_ACTIVE = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_CHAN  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_INACTIVE  = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NOT_READY = 3'd5;

endpackage

`default_nettype wire

FILE: hdl/adc_scan_average_sequencer.sv
// Round-robin ADC scan sequencer with per-channel averaging.
// Input channel (i_in_valid / o_in_stall) carries one item: a conversion
// sample (op 0) or a request for a channel's average (op 1). Output channel
// (o_out_valid / i_out_stall) returns exactly one result per item, in order.
// A sample item passes through the execute and put states before the block
// is idle again; its result is registered in the put state. A read of an
// n-entry buffer walks the sample memory at one entry a cycle, then a shared
// restoring divider produces one quotient bit a cycle; a read item passes
// through the sum, divide, wait and put states before the block is idle
// again. Error reads finish like sample items.
// o_in_stall is high while an item is in progress; a result waits in the
// output register while i_out_stall is high, and the following item is still
// taken and worked through, then held with o_in_stall high until that result
// transfers.
// Reset clears the scan position, the fill indexes, the full flags and the
// configuration registers; the sample memory is not cleared and needs no
// clearing pass. Configuration is to be written only while the block is idle.
`default_nettype none

module adc_scan_average_sequencer #(
    parameter int NUM_CHANNELS  = 4,
    parameter int MAX_AVG_DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_op,
    input  wire logic signed [adcsa_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic [adcsa_pkg::CHAN_IN_W-1:0]        i_channel,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [adcsa_pkg::STATUS_W-1:0]              o_status,
    output logic signed [adcsa_pkg::SAMPLE_W-1:0]      o_mean_value,
    output logic [adcsa_pkg::CODE_W-1:0]                o_mux_code,
    output logic [adcsa_pkg::CODE_W-1:0]                o_gain_code,
    output logic                                        o_switched,
    output logic [adcsa_pkg::SCAN_W-1:0]                o_scan_channel,
    input  wire logic                                   i_cfg_we,
    input  wire logic [adcsa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [adcsa_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import adcsa_pkg::*;

    localparam int CW        = $clog2(NUM_CHANNELS);
    localparam int MEM_DEPTH = NUM_CHANNELS * MAX_AVG_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_DIV,
        ST_WAIT,
        ST_PUT
    } t_state;

    t_state                     r_state;
    logic [COUNT_W-1:0]         r_count [NUM_CHANNELS];
    logic [SETUP_W-1:0]         r_setup [NUM_CHANNELS];
    logic [COUNT_W-1:0]         r_wi    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    r_full;
    logic [CW-1:0]              r_cur;
    logic                       r_settle;

    logic                       r_op;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [CHAN_IN_W-1:0]       r_ch;
    logic [CW-1:0]              r_rd_ch;
    logic [COUNT_W-1:0]         r_n;
    logic [COUNT_W-1:0]         r_k;
    logic                       r_pend;
    logic signed [SUM_W-1:0]    r_sum;

    logic [STATUS_W-1:0]        r_res_status;
    logic signed [SAMPLE_W-1:0] r_res_mean;
    logic                       r_res_sw;

    logic                       r_out_valid;
    logic [STATUS_W-1:0]        r_o_status;
    logic signed [SAMPLE_W-1:0] r_o_mean;
    logic [CODE_W-1:0]          r_o_mux;
    logic [CODE_W-1:0]          r_o_gain;
    logic                       r_o_sw;
    logic [SCAN_W-1:0]          r_o_scan;

    logic [SAMPLE_W-1:0]        r_mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    logic [COUNT_W-1:0]         w_eff [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    w_active;
    logic [CW-1:0]              w_rch;
    logic [CW-1:0]              w_next_start;
    logic [CW:0]                w_find_cur;
    logic [CW:0]                w_find_next;
    logic [COUNT_W:0]           w_wi_inc;
    logic                       w_wrap;
    logic                       w_move;
    logic                       w_rd_go;
    logic                       w_mem_we;
    logic [MEM_AW-1:0]          w_wr_addr;
    logic [MEM_AW-1:0]          w_rd_addr;
    logic                       w_div_start;
    logic                       w_div_done;
    logic signed [SAMPLE_W-1:0] w_div_quo;
    logic                       w_out_free;

    // first active channel from start onwards, cyclic; msb set when found
    function automatic logic [CW:0] find_active(logic [CW-1:0] start,
                                                logic [NUM_CHANNELS-1:0] act);
        logic          found;
        logic [CW-1:0] sel;
        int            s;
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            s = int'(start) + i;
            if (s >= NUM_CHANNELS) begin
                s = s - NUM_CHANNELS;
            end
            if (!found && act[s]) begin
                found = 1'b1;
                sel   = CW'(s);
            end
        end
        return {found, sel};
    endfunction

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            w_eff[c]    = (int'(r_count[c]) > MAX_AVG_DEPTH) ? COUNT_W'(MAX_AVG_DEPTH)
                                                              : r_count[c];
            w_active[c] = (w_eff[c] != '0);
        end
    end

    assign w_rch        = r_ch[CW-1:0];
    assign w_next_start = (int'(r_cur) == NUM_CHANNELS - 1) ? '0 : r_cur + CW'(1);
    assign w_find_cur   = find_active(r_cur, w_active);
    assign w_find_next  = find_active(w_next_start, w_active);
    assign w_wi_inc     = {1'b0, r_wi[r_cur]} + (COUNT_W+1)'(1);
    assign w_wrap       = (w_wi_inc >= {1'b0, w_eff[r_cur]});
    assign w_move       = w_find_next[CW] && (w_find_next[CW-1:0] != r_cur);
    assign w_rd_go      = (r_op == OP_READ) && (int'(r_ch) < NUM_CHANNELS)
                          && w_active[w_rch] && r_full[w_rch];

    assign w_mem_we  = (r_state == ST_EXEC) && (r_op == OP_SAMPLE) && !r_settle
                       && w_active[r_cur];
    assign w_wr_addr = MEM_AW'(int'(r_cur) * MAX_AVG_DEPTH + int'(r_wi[r_cur]));
    assign w_rd_addr = MEM_AW'(int'(r_rd_ch) * MAX_AVG_DEPTH + int'(r_k));

    assign w_div_start = (r_state == ST_DIV);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_mean_value   = r_o_mean;
    assign o_mux_code     = r_o_mux;
    assign o_gain_code    = r_o_gain;
    assign o_switched     = r_o_sw;
    assign o_scan_channel = r_o_scan;

    adcsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // sample memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= r_sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_count[c] <= '0;
                r_setup[c] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (c < NUM_CFG_CH) begin
                    if (i_cfg_index == CFG_COUNT_BASE + CFG_IDX_W'(c)) begin
                        r_count[c] <= i_cfg_data[COUNT_W-1:0];
                    end
                    if (i_cfg_index == CFG_SETUP_BASE + CFG_IDX_W'(c)) begin
                        r_setup[c] <= i_cfg_data[SETUP_W-1:0];
                    end
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_settle    <= 1'b0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_wi[c] <= '0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_PUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_sample <= i_sample;
                        r_ch     <= i_channel;
                        r_state  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_res_mean <= '0;
                    r_state    <= w_rd_go ? ST_SUM : ST_PUT;
                    if (r_op == OP_READ) begin
                        r_res_sw <= 1'b0;
                        if (int'(r_ch) >= NUM_CHANNELS) begin
                            r_res_status <= STS_BAD_CHAN;
                        end else if (!w_active[w_rch]) begin
                            r_res_status <= STS_INACTIVE;
                        end else if (!r_full[w_rch]) begin
                            r_res_status <= STS_NOT_READY;
                        end else begin
                            r_rd_ch <= w_rch;
                            r_n     <= w_eff[w_rch];
                            r_k     <= '0;
                            r_pend  <= 1'b0;
                            r_sum   <= '0;
                        end
                    end else if (r_settle) begin
                        r_settle     <= 1'b0;
                        r_res_status <= STS_DISCARD;
                        r_res_sw     <= 1'b0;
                    end else if (!w_active[r_cur]) begin
                        r_res_sw <= w_find_cur[CW];
                        if (w_find_cur[CW]) begin
                            r_cur        <= w_find_cur[CW-1:0];
                            r_res_status <= STS_DISCARD;
                        end else begin
                            r_res_status <= STS_NO_ACTIVE;
                        end
                    end else begin
                        r_res_status <= STS_OK;
                        r_res_sw     <= w_wrap && w_move;
                        if (w_wrap) begin
                            r_wi[r_cur]   <= '0;
                            r_full[r_cur] <= 1'b1;
                            if (w_move) begin
                                r_cur    <= w_find_next[CW-1:0];
                                r_settle <= 1'b1;
                            end
                        end else begin
                            r_wi[r_cur] <= w_wi_inc[COUNT_W-1:0];
                        end
                    end
                end
                ST_SUM: begin
                    if (r_k < r_n) begin
                        r_k    <= r_k + COUNT_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_sum <= r_sum + {{(SUM_W-SAMPLE_W){r_rd_data[SAMPLE_W-1]}},
                                          r_rd_data};
                    end
                    if ((r_k == r_n) && !r_pend) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_div_done) begin
                        r_res_mean   <= w_div_quo;
                        r_res_status <= STS_OK;
                        r_state      <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_mean    <= r_res_mean;
                        r_o_mux     <= r_setup[r_cur][SETUP_W-1:CODE_W];
                        r_o_gain    <= r_setup[r_cur][CODE_W-1:0];
                        r_o_sw      <= r_res_sw;
                        r_o_scan    <= SCAN_W'(r_cur);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/adcsa_div.sv
`default_nettype none

module adcsa_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [adcsa_pkg::SUM_W-1:0]   i_dividend,
    input  wire logic [adcsa_pkg::COUNT_W-1:0]        i_divisor,
    output logic                                      o_done,
    output logic signed [adcsa_pkg::SAMPLE_W-1:0]     o_quotient
);
    import adcsa_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic                   r_neg;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]       r_quo;
    logic [COUNT_W-1:0]     r_rem;
    logic [COUNT_W-1:0]     r_den;

    logic [COUNT_W:0]       w_trial;
    logic [COUNT_W:0]       w_diff;
    logic                   w_fit;
    logic [SUM_W-1:0]       w_abs;
    logic [MAG_W-1:0]       w_signed;

    assign w_trial  = {r_rem, r_quo[MAG_W-1]};
    assign w_fit    = (w_trial >= {1'b0, r_den});
    assign w_diff   = w_trial - {1'b0, r_den};
    assign w_abs    = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
    assign w_signed = r_neg ? (~r_quo + MAG_W'(1)) : r_quo;

    assign o_done     = r_done;
    assign o_quotient = w_signed[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(MAG_W);
                r_neg  <= i_dividend[SUM_W-1];
                r_quo  <= w_abs[MAG_W-1:0];
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                // one restoring step per cycle
                r_rem <= w_fit ? w_diff[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], w_fit};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire
